@@ hdl/deque_with_search_and_order_scan_macros.svh @@
// assertion macros for the deque with search and order scan
// expects signals named clock and reset in the module that uses them
`ifndef DEQUE_WITH_SEARCH_AND_ORDER_SCAN_MACROS_SVH
`define DEQUE_WITH_SEARCH_AND_ORDER_SCAN_MACROS_SVH

// same-cycle implication
`define DQSOS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque check failed");

// next-cycle implication
`define DQSOS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

@@ hdl/dqsos_pkg.sv @@
// shared types and constants for the deque with search and order scan
// no dependencies
`default_nettype none

package dqsos_pkg;

   localparam int DEPTH_DEF = 32;
   localparam int DATA_W    = 32;
   localparam int COUNT_W   = 6;
   localparam int OPCODE_W  = 3;
   localparam int STATUS_W  = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4,
      OP_SCAN       = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type               opcode;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic                     found;
      logic signed [DATA_W-1:0] element;
      logic                     element_valid;
      logic [COUNT_W-1:0]       count;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic take_left;
      logic take_right;
      logic load;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ hdl/deque_with_search_and_order_scan.sv @@
// Bounded deque of signed 32-bit values held in a row of DEPTH cells, front element in cell 0.
// Push and pop items finish in the cycle they are accepted and give one result. Search and
// order scan rotate the whole row once around, one cell per cycle unless the result side stalls,
// and then give a final result; the scan gives one result per reported element and marks the
// final one with last. A new item is taken only when the previous one is finished and the
// output register is free or being emptied.
// Depends on dqsos_pkg, dqsos_cell and deque_with_search_and_order_scan_macros.svh.
`default_nettype none

module deque_with_search_and_order_scan #(
   parameter int DEPTH = dqsos_pkg::DEPTH_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire dqsos_pkg::req_type req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output dqsos_pkg::rsp_type rsp_data
);
   import dqsos_pkg::*;
   `include "deque_with_search_and_order_scan_macros.svh"

   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_FIN  = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         step_ff, step_in;
   opcode_type               op_ff, op_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic signed [DATA_W-1:0] pend_ff, pend_in;
   logic                     pend_v_ff, pend_v_in;
   logic                     found_ff, found_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic signed [DATA_W-1:0] cell_q [DEPTH];
   cell_ctrl_type            cell_ctrl [DEPTH];
   logic                     shift_l, shift_r;
   logic [DEPTH-1:0]         load_vec;

   logic                     out_free, accept, emit, adv, in_range, qual, hit;
   rsp_type                  emit_rsp;
   logic signed [DATA_W-1:0] cur, nxt, prv;

   // cell row
   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic signed [DATA_W-1:0] left_d;
         if (gi == 0) begin : g_first
            assign left_d = req_data.value;
         end else begin : g_rest
            assign left_d = cell_q[gi-1];
         end
         assign cell_ctrl[gi] = '{take_left: shift_l, take_right: shift_r, load: load_vec[gi]};
         dqsos_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[gi]),
            .from_left  (left_d),
            .from_right (cell_q[(gi + 1) % DEPTH]),
            .load_value (req_data.value),
            .q          (cell_q[gi])
         );
      end
   endgenerate

   assign cur = cell_q[0];
   assign nxt = cell_q[1];
   assign prv = cell_q[DEPTH-1];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // neighbor tests at the row head
   assign in_range = step_ff < count_ff;
   assign qual     = in_range
                   && ((step_ff == '0) || (prv <= cur))
                   && (((step_ff + CNT_W'(1)) >= count_ff) || (cur <= nxt));
   assign hit      = in_range && (cur == key_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      found_in  = found_ff;
      shift_l   = 1'b0;
      shift_r   = 1'b0;
      load_vec  = '0;
      emit      = 1'b0;
      adv       = 1'b0;
      emit_rsp  = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               emit = 1'b1;
               emit_rsp.status = ST_DONE;
               case (req_data.opcode)
                  OP_PUSH_FRONT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        emit_rsp.status = ST_FULL;
                     end else begin
                        shift_l  = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        emit_rsp.status = ST_FULL;
                     end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                           load_vec[i] = (count_ff == CNT_W'(i));
                        end
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (count_ff == '0) begin
                        emit_rsp.status = ST_EMPTY;
                     end else begin
                        shift_r  = 1'b1;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (count_ff == '0) begin
                        emit_rsp.status = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_SEARCH, OP_SCAN: begin
                     emit      = 1'b0;
                     state_in  = S_WALK;
                     step_in   = '0;
                     op_in     = req_data.opcode;
                     key_in    = req_data.value;
                     pend_v_in = 1'b0;
                     found_in  = 1'b0;
                  end
                  default: begin
                     emit_rsp.status = ST_DONE;
                  end
               endcase
               emit_rsp.count = COUNT_W'(count_in);
               emit_rsp.last  = 1'b1;
            end
         end
         S_WALK: begin
            // a newly qualifying element pushes out the one held back
            if ((op_ff == OP_SCAN) && qual && pend_v_ff) begin
               adv  = out_free;
               emit = out_free;
            end else begin
               adv = 1'b1;
            end
            emit_rsp.status        = ST_DONE;
            emit_rsp.element       = pend_ff;
            emit_rsp.element_valid = 1'b1;
            emit_rsp.count         = COUNT_W'(count_ff);
            emit_rsp.last          = 1'b0;
            if (adv) begin
               shift_r = 1'b1;
               step_in = step_ff + CNT_W'(1);
               if (qual) begin
                  pend_in   = cur;
                  pend_v_in = 1'b1;
               end
               if (hit) begin
                  found_in = 1'b1;
               end
               if (step_ff == CNT_W'(DEPTH - 1)) begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            emit_rsp.status = ST_DONE;
            emit_rsp.count  = COUNT_W'(count_ff);
            emit_rsp.last   = 1'b1;
            if (op_ff == OP_SCAN) begin
               emit_rsp.element       = pend_v_ff ? pend_ff : '0;
               emit_rsp.element_valid = pend_v_ff;
            end else begin
               emit_rsp.found = found_ff;
            end
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      pend_ff   <= pend_in;
      pend_v_ff <= pend_v_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DQSOS_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH))
   `DQSOS_ASSERT_IMPL(a_busy_no_accept, state_ff != S_IDLE, !req_ready)
   `DQSOS_ASSERT_IMPL(a_walk_step, state_ff == S_WALK, step_ff < CNT_W'(DEPTH))
   `DQSOS_ASSERT_NEXT(a_fin_to_idle, (state_ff == S_FIN) && out_free, state_ff == S_IDLE)
   `DQSOS_ASSERT_IMPL(a_walk_count_stable, state_ff != S_IDLE, count_in == count_ff)

endmodule

`default_nettype wire

@@ hdl/dqsos_cell.sv @@
// one storage cell of the deque chain, holds one element
// depends on dqsos_pkg
`default_nettype none

module dqsos_cell (
   input  wire                              clock,
   input  wire dqsos_pkg::cell_ctrl_type    ctrl,
   input  wire signed [dqsos_pkg::DATA_W-1:0] from_left,
   input  wire signed [dqsos_pkg::DATA_W-1:0] from_right,
   input  wire signed [dqsos_pkg::DATA_W-1:0] load_value,
   output logic signed [dqsos_pkg::DATA_W-1:0] q
);
   import dqsos_pkg::*;

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.take_left) begin
         data_in = from_left;
      end else if (ctrl.take_right) begin
         data_in = from_right;
      end else if (ctrl.load) begin
         data_in = load_value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

`default_nettype wire
